// File: design/che_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// che_pkg
// Shared types and constants for the three-way cuckoo table with expiry.
// ----------------------------------------------------------------------------
package che_pkg;

    localparam int TABLE_BITS_DEF = 10;
    localparam int MAX_ROUNDS_DEF = 10;

    localparam int KEY_W    = 64;
    localparam int SEQ_W    = 64;
    localparam int DEVICE_W = 8;
    localparam int BUCKET_W = 56;

    localparam logic [63:0] GOLDEN64 = 64'h61C8_8646_80B5_83EB;

    typedef enum logic [1:0] {
        REQ_QUERY  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        REG_SEED_A = 2'd0,
        REG_SEED_B = 2'd1,
        REG_SEED_C = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

endpackage

// File: design/che_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// che_hash
// Multiplicative hash: top bits of (x * golden) mod 2^64, built from three
// 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module che_hash #(
    parameter int TABLE_BITS = che_pkg::TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           operand,
    output logic                  done,
    output logic [TABLE_BITS-1:0] idx
);
    import che_pkg::*;

    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [1:0]  step_reg;
    logic        run_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_a = x_reg[31:0];
                mul_b = GOLDEN64[31:0];
            end
            2'd1:
            begin
                mul_a = x_reg[31:0];
                mul_b = GOLDEN64[63:32];
            end
            default:
            begin
                mul_a = x_reg[63:32];
                mul_b = GOLDEN64[31:0];
            end
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
        if (step_reg == 2'd0)
            acc_next = prod;
        else
            acc_next = acc_reg + {prod[31:0], 32'd0};
    end

    assign done = run_reg && (step_reg == 2'd2);
    assign idx  = acc_next[63 -: TABLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd2)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            x_reg <= operand;
        if (run_reg)
            acc_reg <= acc_next;
    end

endmodule

// File: design/cuckoo_hash_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_with_expiry
// Three-way cuckoo table of (key, sequence) entries with sequence expiry.
// ----------------------------------------------------------------------------
// Each probe passes through S_HSTART, S_HASH (the three partial products on
//   the shared 32x32 multiplier), S_READ (table read) and S_CHECK; a query
//   makes up to 3 probes, an insert up to MAX_ROUNDS rounds of 3 probes and
//   a swap, and a clear writes each of the 2^TABLE_BITS entries.
// Throughput: one transaction at a time; busy stays high until done pulses.
// Reset: a clearing pass over all 2^TABLE_BITS entries zeroes the table; busy is held.
// Done is shown for one cycle; the result holds until the next start and the receiver cannot stall it.
module cuckoo_hash_with_expiry #(
    parameter int TABLE_BITS = che_pkg::TABLE_BITS_DEF,
    parameter int MAX_ROUNDS = che_pkg::MAX_ROUNDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [che_pkg::SEQ_W-1:0]     flushed_seq,
    input  logic [che_pkg::DEVICE_W-1:0]  device,
    input  logic [che_pkg::BUCKET_W-1:0]  bucket,
    input  logic [che_pkg::SEQ_W-1:0]     entry_seq,
    // result
    output logic                          done,
    output logic                          needs_commit,
    output logic                          insert_ok,
    output logic [che_pkg::DEVICE_W-1:0]  spill_device,
    output logic [che_pkg::BUCKET_W-1:0]  spill_bucket,
    output logic [che_pkg::SEQ_W-1:0]     spill_seq
);
    import che_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int RW         = $clog2(MAX_ROUNDS + 1);
    localparam int ENTRY_W    = KEY_W + SEQ_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_HSTART = 7'b0000100,
        S_HASH   = 7'b0001000,
        S_READ   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_SWAP   = 7'b1000000
    } state_t;

    // configuration registers
    logic [63:0] seed_a_reg;
    logic [63:0] seed_b_reg;
    logic [63:0] seed_c_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // sequencer state
    state_t                state_reg,   state_next;
    logic                  is_ins_reg,  is_ins_next;
    logic                  clr_req_reg, clr_req_next;
    logic [TABLE_BITS-1:0] clr_ix_reg,  clr_ix_next;
    logic [1:0]            probe_reg,   probe_next;
    logic [RW-1:0]         round_reg,   round_next;
    logic                  have_last_reg, have_last_next;
    logic [TABLE_BITS-1:0] last_ix_reg, last_ix_next;
    logic                  have_vic_reg, have_vic_next;
    logic [TABLE_BITS-1:0] vic_ix_reg,  vic_ix_next;
    logic [KEY_W-1:0]      vic_key_reg, vic_key_next;
    logic [SEQ_W-1:0]      vic_seq_reg, vic_seq_next;
    logic [TABLE_BITS-1:0] ix_reg,      ix_next;
    logic [KEY_W-1:0]      key_reg,     key_next;
    logic [SEQ_W-1:0]      seq_reg,     seq_next;
    logic [SEQ_W-1:0]      flushed_reg, flushed_next;

    // result registers
    logic                  done_reg,    done_next;
    logic                  commit_reg,  commit_next;
    logic                  ok_reg,      ok_next;
    logic [KEY_W-1:0]      spkey_reg,   spkey_next;
    logic [SEQ_W-1:0]      spseq_reg,   spseq_next;

    // table memory
    logic [ENTRY_W-1:0]    mem [TABLE_SIZE];
    logic [ENTRY_W-1:0]    rd_reg;
    logic                  mem_we;
    logic [TABLE_BITS-1:0] mem_wa;
    logic [ENTRY_W-1:0]    mem_wd;
    logic [KEY_W-1:0]      rd_key;
    logic [SEQ_W-1:0]      rd_seq;

    // hash unit
    logic                  hash_start;
    logic [63:0]           hash_operand;
    logic                  hash_done;
    logic [TABLE_BITS-1:0] hash_idx;
    logic [63:0]           seed_sel;

    logic                  hit;
    logic                  usable;

    // ------------------------------------------------------------------
    // Configuration port: register i at byte address 8*i
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_comb
    begin
        case (cfg_idx)
            REG_SEED_A: prdata = seed_a_reg;
            REG_SEED_B: prdata = seed_b_reg;
            REG_SEED_C: prdata = seed_c_reg;
            default:    prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= 64'd0;
            seed_b_reg <= 64'd0;
            seed_c_reg <= 64'd0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SEED_A: seed_a_reg <= pwdata;
                REG_SEED_B: seed_b_reg <= pwdata;
                REG_SEED_C: seed_c_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Hash unit, shared by all probes
    // ------------------------------------------------------------------
    always_comb
    begin
        case (probe_reg)
            2'd0:    seed_sel = seed_a_reg;
            2'd1:    seed_sel = seed_b_reg;
            default: seed_sel = seed_c_reg;
        endcase
    end

    assign hash_start   = (state_reg == S_HSTART);
    assign hash_operand = key_reg ^ seed_sel;

    che_hash #(
        .TABLE_BITS (TABLE_BITS)
    ) u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (hash_start),
        .operand (hash_operand),
        .done    (hash_done),
        .idx     (hash_idx)
    );

    // ------------------------------------------------------------------
    // Table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[ix_reg];
    end

    assign rd_key = rd_reg[ENTRY_W-1 -: KEY_W];
    assign rd_seq = rd_reg[SEQ_W-1:0];
    assign hit    = (rd_key == key_reg);
    assign usable = !have_last_reg || (last_ix_reg != ix_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        is_ins_next    = is_ins_reg;
        clr_req_next   = clr_req_reg;
        clr_ix_next    = clr_ix_reg;
        probe_next     = probe_reg;
        round_next     = round_reg;
        have_last_next = have_last_reg;
        last_ix_next   = last_ix_reg;
        have_vic_next  = have_vic_reg;
        vic_ix_next    = vic_ix_reg;
        vic_key_next   = vic_key_reg;
        vic_seq_next   = vic_seq_reg;
        ix_next        = ix_reg;
        key_next       = key_reg;
        seq_next       = seq_reg;
        flushed_next   = flushed_reg;
        done_next      = 1'b0;
        commit_next    = commit_reg;
        ok_next        = ok_reg;
        spkey_next     = spkey_reg;
        spseq_next     = spseq_reg;
        mem_we         = 1'b0;
        mem_wa         = ix_reg;
        mem_wd         = {key_reg, seq_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // take the transaction and clear the previous result
                    key_next       = {device, bucket};
                    seq_next       = entry_seq;
                    flushed_next   = flushed_seq;
                    is_ins_next    = (req_type == REQ_INSERT);
                    probe_next     = 2'd0;
                    round_next     = '0;
                    have_last_next = 1'b0;
                    have_vic_next  = 1'b0;
                    commit_next    = 1'b0;
                    ok_next        = 1'b0;
                    spkey_next     = '0;
                    spseq_next     = '0;
                    case (req_type)
                        REQ_QUERY, REQ_INSERT:
                            state_next = S_HSTART;
                        REQ_CLEAR:
                        begin
                            clr_req_next = 1'b1;
                            clr_ix_next  = '0;
                            state_next   = S_CLEAR;
                        end
                        default:
                            done_next = 1'b1;
                    endcase
                end
            end

            S_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wa      = clr_ix_reg;
                mem_wd      = '0;
                clr_ix_next = clr_ix_reg + 1'b1;
                if (&clr_ix_reg)
                begin
                    done_next    = clr_req_reg;
                    clr_req_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            S_HSTART:
                state_next = S_HASH;

            S_HASH:
            begin
                if (hash_done)
                begin
                    ix_next    = hash_idx;
                    state_next = S_READ;
                end
            end

            S_READ:
                state_next = S_CHECK;

            S_CHECK:
            begin
                if (!is_ins_reg)
                begin
                    if (hit)
                    begin
                        commit_next = (rd_seq > flushed_reg);
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (probe_reg == 2'd2)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        probe_next = probe_reg + 2'd1;
                        state_next = S_HSTART;
                    end
                end
                else if (hit || (rd_seq <= flushed_reg))
                begin
                    // overwrite a matching or expired slot
                    mem_we     = 1'b1;
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (usable)
                    begin
                        have_vic_next = 1'b1;
                        vic_ix_next   = ix_reg;
                        vic_key_next  = rd_key;
                        vic_seq_next  = rd_seq;
                    end
                    if (probe_reg != 2'd2)
                    begin
                        probe_next = probe_reg + 2'd1;
                        state_next = S_HSTART;
                    end
                    else if (usable || have_vic_reg)
                        state_next = S_SWAP;
                    else
                    begin
                        // no victim other than the previous one: give up
                        spkey_next = key_reg;
                        spseq_next = seq_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            S_SWAP:
            begin
                // place the entry in the victim slot and carry the victim on
                mem_we         = 1'b1;
                mem_wa         = vic_ix_reg;
                key_next       = vic_key_reg;
                seq_next       = vic_seq_reg;
                have_last_next = 1'b1;
                last_ix_next   = vic_ix_reg;
                have_vic_next  = 1'b0;
                probe_next     = 2'd0;
                round_next     = round_reg + 1'b1;
                if (round_reg == RW'(MAX_ROUNDS - 1))
                begin
                    spkey_next = vic_key_reg;
                    spseq_next = vic_seq_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_HSTART;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // start with a clearing pass over the whole table
            state_reg   <= S_CLEAR;
            clr_req_reg <= 1'b0;
            clr_ix_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_req_reg <= clr_req_next;
            clr_ix_reg  <= clr_ix_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_ins_reg    <= is_ins_next;
        probe_reg     <= probe_next;
        round_reg     <= round_next;
        have_last_reg <= have_last_next;
        last_ix_reg   <= last_ix_next;
        have_vic_reg  <= have_vic_next;
        vic_ix_reg    <= vic_ix_next;
        vic_key_reg   <= vic_key_next;
        vic_seq_reg   <= vic_seq_next;
        ix_reg        <= ix_next;
        key_reg       <= key_next;
        seq_reg       <= seq_next;
        flushed_reg   <= flushed_next;
        commit_reg    <= commit_next;
        ok_reg        <= ok_next;
        spkey_reg     <= spkey_next;
        spseq_reg     <= spseq_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign needs_commit = commit_reg;
    assign insert_ok    = ok_reg;
    assign spill_device = spkey_reg[KEY_W-1 -: DEVICE_W];
    assign spill_bucket = spkey_reg[BUCKET_W-1:0];
    assign spill_seq    = spseq_reg;

endmodule
